FILE: hw/rtl/tea_block_encrypt_defines.svh
// ----------------------------------------------------------------------------
// TEA block encrypt assertion macros
// Shared concurrent check macros; define NO_ASSERTIONS to compile them out.
// ----------------------------------------------------------------------------
`ifndef TEA_BLOCK_ENCRYPT_DEFINES_SVH
`define TEA_BLOCK_ENCRYPT_DEFINES_SVH

`ifndef NO_ASSERTIONS

// Check a consequence in the same cycle as its condition
`define TEA_ASSERT_SAME(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

// Check a consequence in the cycle after its condition
`define TEA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`else

`define TEA_ASSERT_SAME(label, clk, rst_n, ante, cons)
`define TEA_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

FILE: hw/rtl/tea_pkg.sv
// ----------------------------------------------------------------------------
// TEA block encrypt package
// Widths, round constants, register indexes and pipeline word types.
// ----------------------------------------------------------------------------
package tea_pkg;

  localparam int ROUNDS   = 32;
  localparam int STAGES   = 2 * ROUNDS;  // one half-round per stage
  localparam int CHECK_STAGE = STAGES / 2;  // middle stage watched by the checks
  localparam int WORD_W   = 32;
  localparam int DATA_W   = 2 * WORD_W;
  localparam int COUNT_W  = 4;
  localparam int BYTES    = DATA_W / 8;
  localparam int CFG_IDX_W = 3;

  localparam logic [WORD_W-1:0]  TEA_DELTA  = 32'h9e37_79b9;
  localparam logic [COUNT_W-1:0] FULL_COUNT = COUNT_W'(BYTES);

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_KEY_0      = 3'd0,
    CFG_KEY_1      = 3'd1,
    CFG_KEY_2      = 3'd2,
    CFG_KEY_3      = 3'd3,
    CFG_ENABLE     = 3'd4
  } tea_cfg_idx_t;

  // Key words, little-endian key bytes 0..15
  typedef struct packed {
    logic [WORD_W-1:0] k3;
    logic [WORD_W-1:0] k2;
    logic [WORD_W-1:0] k1;
    logic [WORD_W-1:0] k0;
  } tea_key_t;

  // Word carried down the pipeline
  typedef struct packed {
    logic [WORD_W-1:0]  v1;
    logic [WORD_W-1:0]  v0;
    logic [COUNT_W-1:0] count;
    logic               tea;   // apply rounds; clear for tail and pass-through
  } tea_stage_t;

  // Running sum after round r (0-based)
  function automatic logic [WORD_W-1:0] round_sum(input int unsigned r);
    logic [WORD_W-1:0] n;
    n = WORD_W'(r + 1);
    return TEA_DELTA * n;
  endfunction

endpackage

FILE: hw/rtl/tea_channels.sv
// ----------------------------------------------------------------------------
// TEA block encrypt channels
// Valid/ready interfaces for the input group word and the result word.
// ----------------------------------------------------------------------------
interface tea_in_if import tea_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [DATA_W-1:0]  block_data;
  logic [COUNT_W-1:0] byte_count;
  logic               tail_key_half;

  modport source (output valid, block_data, byte_count, tail_key_half, input ready);
  modport sink   (input valid, block_data, byte_count, tail_key_half, output ready);
endinterface

interface tea_out_if import tea_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [DATA_W-1:0]  result_data;
  logic [COUNT_W-1:0] result_count;

  modport source (output valid, result_data, result_count, input ready);
  modport sink   (input valid, result_data, result_count, output ready);
endinterface

FILE: hw/rtl/tea_block_encrypt.sv
// ----------------------------------------------------------------------------
// TEA block encrypt
// Encrypts 8-byte groups with 32-round TEA, XORs short tail groups with key
// bytes, or passes data through when encryption is off.
// ----------------------------------------------------------------------------
//  Channel   Dir  Handshake         Payload
//  in_blk    in   valid/ready       block_data, byte_count, tail_key_half
//  out_blk   out  valid/ready       result_data, result_count
//  cfg_*     in   cfg_we (no wait)  cfg_index, cfg_wdata
//
//  One word per cycle sustained while out_blk takes its words. The path is one entry
//  stage, then one register per half-round of TEA.
//  Reset clears the valid bits, the key words and the enable bit.
//  A result word left untaken at the output freezes the whole pipeline; in_blk
//  ready drops in the same cycle and no word is lost or repeated.
// ----------------------------------------------------------------------------
`include "tea_block_encrypt_defines.svh"

module tea_block_encrypt import tea_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  tea_in_if.sink               in_blk,
  tea_out_if.source            out_blk,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [WORD_W-1:0]    cfg_wdata
);

  tea_key_t          key_r;
  logic              enable_r;
  logic              adv;
  logic              entry_valid_r;
  tea_stage_t        entry_r;
  tea_stage_t        entry_nxt;
  logic [DATA_W-1:0] pad;
  logic [DATA_W-1:0] mask;
  logic              full;
  logic [STAGES:0]   stg_valid;
  tea_stage_t        stg_data [0:STAGES];

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_r    <= '0;
      enable_r <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index) inside
        CFG_KEY_0: key_r.k0 <= cfg_wdata;
        CFG_KEY_1: key_r.k1 <= cfg_wdata;
        CFG_KEY_2: key_r.k2 <= cfg_wdata;
        CFG_KEY_3: key_r.k3 <= cfg_wdata;
        CFG_ENABLE: enable_r <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // Global advance: move whenever the output slot is free or being taken
  assign adv          = !stg_valid[STAGES] || out_blk.ready;
  assign in_blk.ready = adv;

  // Entry: classify the group, apply the tail XOR up front
  always_comb begin
    pad  = in_blk.tail_key_half ? {key_r.k3, key_r.k2} : {key_r.k1, key_r.k0};
    full = in_blk.byte_count >= FULL_COUNT;
    for (int j = 0; j < BYTES; j++) begin
      mask[j*8 +: 8] = (COUNT_W'(j) < in_blk.byte_count) ? 8'hFF : 8'h00;
    end
    entry_nxt.count = in_blk.byte_count;
    entry_nxt.tea   = enable_r && full;
    if (enable_r && !full) begin
      {entry_nxt.v1, entry_nxt.v0} = in_blk.block_data ^ (pad & mask);
    end else begin
      {entry_nxt.v1, entry_nxt.v0} = in_blk.block_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      entry_valid_r <= 1'b0;
    end else if (adv) begin
      entry_valid_r <= in_blk.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      entry_r <= entry_nxt;
    end
  end

  assign stg_valid[0] = entry_valid_r;
  assign stg_data[0]  = entry_r;

  // Half-round stages: even stages update v0, odd stages update v1
  for (genvar s = 0; s < STAGES; s++) begin : g_stage
    tea_stage u_stage (
      .clk      (clk),
      .rst_n    (rst_n),
      .adv      (adv),
      .upper    (1'(s % 2)),
      .sum      (round_sum(s / 2)),
      .key      (key_r),
      .valid_in (stg_valid[s]),
      .word_in  (stg_data[s]),
      .valid_o  (stg_valid[s+1]),
      .word_o   (stg_data[s+1])
    );
  end

  // Output from the last stage register
  assign out_blk.valid        = stg_valid[STAGES];
  assign out_blk.result_data  = {stg_data[STAGES].v1, stg_data[STAGES].v0};
  assign out_blk.result_count = stg_data[STAGES].count;

  // Checks
  `TEA_ASSERT_SAME(a_ready_when_empty, clk, rst_n, !stg_valid[STAGES], in_blk.ready)
  `TEA_ASSERT_NEXT(a_stall_freezes, clk, rst_n, !adv, $stable(stg_valid))
  `TEA_ASSERT_NEXT(a_off_no_rounds, clk, rst_n, in_blk.valid && in_blk.ready && !enable_r, !entry_r.tea)
  `TEA_ASSERT_NEXT(a_valid_moves, clk, rst_n, adv && stg_valid[CHECK_STAGE], stg_valid[CHECK_STAGE+1])
  `TEA_ASSERT_NEXT(a_bypass_kept, clk, rst_n, adv && stg_valid[CHECK_STAGE] && !stg_data[CHECK_STAGE].tea, stg_data[CHECK_STAGE+1] == $past(stg_data[CHECK_STAGE]))

endmodule

FILE: hw/rtl/tea_stage.sv
// ----------------------------------------------------------------------------
// TEA half-round stage
// One half of a TEA round followed by the stage register; holds on stall.
// ----------------------------------------------------------------------------
module tea_stage import tea_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              adv,
  input  logic              upper,    // 1 updates v1 from v0, 0 updates v0 from v1
  input  logic [WORD_W-1:0] sum,
  input  tea_key_t          key,
  input  logic              valid_in,
  input  tea_stage_t        word_in,
  output logic              valid_o,
  output tea_stage_t        word_o
);

  logic              valid_r;
  tea_stage_t        word_r;
  tea_stage_t        word_nxt;
  logic [WORD_W-1:0] src;
  logic [WORD_W-1:0] ka;
  logic [WORD_W-1:0] kb;
  logic [WORD_W-1:0] mix;

  // Mix function of the half-round
  always_comb begin
    src = upper ? word_in.v0 : word_in.v1;
    ka  = upper ? key.k2 : key.k0;
    kb  = upper ? key.k3 : key.k1;
    mix = ((src << 4) + ka) ^ (src + sum) ^ ((src >> 5) + kb);
  end

  // Add the mix into the selected half when the word is a full block
  always_comb begin
    word_nxt = word_in;
    if (word_in.tea) begin
      if (upper) begin
        word_nxt.v1 = word_in.v1 + mix;
      end else begin
        word_nxt.v0 = word_in.v0 + mix;
      end
    end
  end

  // Advance the stage, hold on stall
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (adv) begin
      valid_r <= valid_in;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      word_r <= word_nxt;
    end
  end

  assign valid_o = valid_r;
  assign word_o  = word_r;

endmodule

FILE: test/tb_tea_block_encrypt.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// TEA block encrypt testbench
// Sends byte groups through the input channel with random gaps while the
// result channel stalls at random. A local copy of the key words and the
// enable bit predicts every result word, and each result word is compared
// field by field against the oldest prediction. Keys and enable change only
// while the pipeline is empty.
// ----------------------------------------------------------------------------
module tb_tea_block_encrypt;
  import tea_pkg::*;

  localparam int IDLE_PCT      = 37;
  localparam int DRAIN_WAIT    = 2 * ROUNDS + 8;
  localparam int CYCLE_LIMIT   = 400000;
  localparam int RANDOM_PHASES = 8;
  localparam int PHASE_WORDS   = 250;

  typedef struct packed {
    logic [DATA_W-1:0]  data;
    logic [COUNT_W-1:0] count;
  } group_result_t;

  logic              clk;
  logic              rst_n;
  logic              cfg_we;
  tea_cfg_idx_t      cfg_index;
  logic [WORD_W-1:0] cfg_wdata;

  tea_in_if  in_ch ();
  tea_out_if out_ch ();

  // Local copy of the register state
  tea_key_t cipher_key;
  logic     encrypt_on;

  bit            idle_on;
  group_result_t pending_results[$];
  int unsigned   error_count;
  int unsigned   cycle_count;

  tea_block_encrypt dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_blk    (in_ch),
    .out_blk   (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Encrypt one full group with the current key
  function automatic logic [DATA_W-1:0] tea_encipher(input logic [DATA_W-1:0] plain);
    logic [WORD_W-1:0] v0;
    logic [WORD_W-1:0] v1;
    logic [WORD_W-1:0] sum;
    v0  = plain[WORD_W-1:0];
    v1  = plain[DATA_W-1:WORD_W];
    sum = '0;
    for (int r = 0; r < ROUNDS; r++) begin
      sum = sum + TEA_DELTA;
      v0 = v0 + ((((v1 << 4) + cipher_key.k0) ^ (v1 + sum)) ^ ((v1 >> 5) + cipher_key.k1));
      v1 = v1 + ((((v0 << 4) + cipher_key.k2) ^ (v0 + sum)) ^ ((v0 >> 5) + cipher_key.k3));
    end
    return {v1, v0};
  endfunction

  // Work out the result word for one group
  function automatic group_result_t group_result(input logic [DATA_W-1:0] data,
                                                 input logic [COUNT_W-1:0] count,
                                                 input logic half);
    group_result_t res;
    logic [DATA_W-1:0] pad;
    logic [DATA_W-1:0] mask;
    res.data  = data;
    res.count = count;
    if (encrypt_on) begin
      if (count >= FULL_COUNT) begin
        res.data = tea_encipher(data);
      end else begin
        // XOR valid tail bytes with one half of the key bytes
        pad  = half ? {cipher_key.k3, cipher_key.k2} : {cipher_key.k1, cipher_key.k0};
        mask = (64'd1 << (32'(count) * 8)) - 64'd1;
        res.data = data ^ (pad & mask);
      end
    end
    return res;
  endfunction

  function automatic logic [DATA_W-1:0] random_word();
    return {$urandom, $urandom};
  endfunction

  // Write one register and track it locally
  task automatic write_reg(input tea_cfg_idx_t idx, input logic [WORD_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    case (idx)
      CFG_KEY_0:  cipher_key.k0 = value;
      CFG_KEY_1:  cipher_key.k1 = value;
      CFG_KEY_2:  cipher_key.k2 = value;
      CFG_KEY_3:  cipher_key.k3 = value;
      CFG_ENABLE: encrypt_on = value[0];
      default: ;
    endcase
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic load_key(input tea_key_t key);
    write_reg(CFG_KEY_0, key.k0);
    write_reg(CFG_KEY_1, key.k1);
    write_reg(CFG_KEY_2, key.k2);
    write_reg(CFG_KEY_3, key.k3);
  endtask

  // Send one group word; hold valid until the handshake completes
  task automatic send_group(input logic [DATA_W-1:0] data,
                            input logic [COUNT_W-1:0] count,
                            input logic half);
    if (idle_on && $urandom_range(99) < IDLE_PCT) begin
      in_ch.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < IDLE_PCT);
    end
    in_ch.valid         <= 1'b1;
    in_ch.block_data    <= data;
    in_ch.byte_count    <= count;
    in_ch.tail_key_half <= half;
    do @(posedge clk); while (!in_ch.ready);
    pending_results.push_back(group_result(data, count, half));
  endtask

  // Drop valid and wait until every expected result word has come back
  task automatic drain_results();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (pending_results.size() != 0);
  endtask

  // Reset state: encryption off, so every group passes through
  task automatic test_reset_passthrough();
    send_group('0, FULL_COUNT, 1'b0);
    send_group('1, 4'd15, 1'b1);
    send_group(64'h0123_4567_89ab_cdef, 4'd0, 1'b0);
    send_group(64'hfedc_ba98_7654_3210, 4'd3, 1'b0);
    drain_results();
  endtask

  // Enable only: key words must come out of reset as zero
  task automatic test_reset_key_zero();
    write_reg(CFG_ENABLE, 32'd1);
    send_group('0, FULL_COUNT, 1'b0);
    send_group('1, FULL_COUNT, 1'b1);
    send_group('1, 4'd7, 1'b1);
    drain_results();
  endtask

  // Tail lengths, key halves, zero count and counts above a full group
  task automatic test_directed_cases();
    load_key({32'h0f1e_2d3c, 32'h4b5a_6978, 32'h8796_a5b4, 32'hc3d2_e1f0});
    send_group('1, FULL_COUNT, 1'b1);
    send_group('0, 4'd1, 1'b0);
    send_group('1, 4'd1, 1'b1);
    send_group(64'h0123_4567_89ab_cdef, 4'd7, 1'b0);
    send_group(64'h0123_4567_89ab_cdef, 4'd7, 1'b1);
    send_group(64'hdead_beef_cafe_f00d, 4'd4, 1'b1);
    send_group(64'hdead_beef_cafe_f00d, 4'd0, 1'b1);
    send_group(64'h5555_aaaa_3333_cccc, 4'd9, 1'b0);
    send_group(64'h5555_aaaa_3333_cccc, 4'd15, 1'b1);
    drain_results();
  endtask

  // All-ones key, then encryption off with a nonzero key
  task automatic test_key_extremes();
    load_key('1);
    send_group('1, FULL_COUNT, 1'b0);
    send_group('0, FULL_COUNT, 1'b1);
    send_group('0, 4'd7, 1'b0);
    send_group('0, 4'd6, 1'b1);
    drain_results();
    write_reg(CFG_ENABLE, 32'd0);
    send_group(random_word(), FULL_COUNT, 1'b0);
    send_group(random_word(), 4'd5, 1'b1);
    drain_results();
  endtask

  // Buffers of full groups closed by a tail, mixed with arbitrary groups
  task automatic test_random_buffers(input int unsigned phase);
    tea_key_t    key;
    int unsigned sent;
    int unsigned groups;
    case (phase)
      0:       key = '1;
      1:       key = '0;
      default: key = {$urandom, $urandom, $urandom, $urandom};
    endcase
    load_key(key);
    write_reg(CFG_ENABLE, WORD_W'(phase != 2));
    idle_on = (phase != 3);
    sent = 0;
    while (sent < PHASE_WORDS) begin
      if ($urandom_range(99) < 12) begin
        send_group(random_word(), COUNT_W'($urandom_range(15)), 1'($urandom_range(1)));
        sent++;
      end else begin
        groups = $urandom_range(12);
        for (int g = 0; g < groups; g++) begin
          send_group(random_word(), FULL_COUNT, 1'($urandom_range(1)));
        end
        sent += groups;
        // Tail key half follows the parity of the number of full groups sent before it
        if ($urandom_range(3) != 0) begin
          send_group(random_word(), COUNT_W'($urandom_range(7, 1)), 1'(groups % 2));
          sent++;
        end
      end
    end
    drain_results();
    idle_on = 1'b1;
  endtask

  // Result side: stall at random while idling is on
  initial begin
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      out_ch.ready <= !idle_on || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  // Compare each accepted result word with the oldest prediction
  always @(posedge clk) begin
    group_result_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_results.size() == 0) begin
        $error("result word with nothing expected: result_data %h result_count %0d",
               out_ch.result_data, out_ch.result_count);
        error_count++;
      end else begin
        want = pending_results.pop_front();
        if (out_ch.result_data !== want.data) begin
          $error("result_data mismatch: expected %h, actual %h",
                 want.data, out_ch.result_data);
          error_count++;
        end
        if (out_ch.result_count !== want.count) begin
          $error("result_count mismatch: expected %0d, actual %0d",
                 want.count, out_ch.result_count);
          error_count++;
        end
      end
    end
  end

  // Stop a hung run
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin
    rst_n               <= 1'b0;
    cfg_we              <= 1'b0;
    cfg_index           <= CFG_KEY_0;
    cfg_wdata           <= '0;
    in_ch.valid         <= 1'b0;
    in_ch.block_data    <= '0;
    in_ch.byte_count    <= '0;
    in_ch.tail_key_half <= 1'b0;
    cipher_key  = '0;
    encrypt_on  = 1'b0;
    idle_on     = 1'b1;
    error_count = 0;
    cycle_count = 0;

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_passthrough();
    test_reset_key_zero();
    test_directed_cases();
    test_key_extremes();
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      test_random_buffers(p);
    end

    // Catch any stray result word after the last expected one
    repeat (DRAIN_WAIT) @(posedge clk);
    if (error_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
